// ===== design/tape_image_seven_track_deframer_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Seven-track deframer assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet under reset.
// ---------------------------------------------------------------------------
`ifndef TAPE_IMAGE_SEVEN_TRACK_DEFRAMER_UNIT_DEFINES_SVH
`define TAPE_IMAGE_SEVEN_TRACK_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define TISD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TISD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tisd_pkg.sv =====
// ---------------------------------------------------------------------------
// tisd_pkg
// Types, codes and helpers shared by the seven-track deframer modules.
// ---------------------------------------------------------------------------
package tisd_pkg;

	localparam int REC_LEN_W   = 32;
	localparam int ACC_W       = 30;
	localparam int WORD_W      = 36;
	localparam int SIX_W       = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam logic [2:0] LAST_FRAME = 3'd5;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_DATA    = 2'd1,
		PH_TRAILER = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_WORD     = 2'd0,
		ST_EOT      = 2'd1,
		ST_BADLEN   = 2'd2,
		ST_BADTRAIL = 2'd3
	} status_t;

	typedef enum logic {
		TK_DIGIT  = 1'b0,
		TK_STATUS = 1'b1
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t        kind;
		logic [SIX_W-1:0] six;
		logic             word_last;
		logic             fs;
		logic             rs;
		logic             re;
		status_t          st;
	} token_t;

	// byte mod 3: 4 = 1 (mod 3), so sum the 2-bit digits and fold
	function automatic logic [1:0] mod3_byte(input logic [7:0] b);
		logic [3:0] s;
		logic [2:0] t;
		s = {2'b00, b[1:0]} + {2'b00, b[3:2]} + {2'b00, b[5:4]} + {2'b00, b[7:6]};
		t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
		if (t >= 3'd3) t = t - 3'd3;
		if (t == 3'd3) t = 3'd0;
		return t[1:0];
	endfunction

	function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
		logic [2:0] t;
		t = {1'b0, a} + {1'b0, b};
		if (t >= 3'd3) t = t - 3'd3;
		return t[1:0];
	endfunction

endpackage

// ===== design/tape_image_seven_track_deframer_unit.sv =====
// A word or status request reaches m_tvalid from the tape byte that completes it
// through a token queue entry and then the output register.
// Throughput: one tape byte per cycle, set by the four-entry token queue and
// the single output register; a stalled output fills the queue, then drops s_tready.
// Reset: arst_n clears all control state at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
// tape_image_seven_track_deframer_unit
// Seven-track tape image deframer: record framing front end, token queue,
// word assembly back end.
// ---------------------------------------------------------------------------
`include "tape_image_seven_track_deframer_unit_defines.svh"

module tape_image_seven_track_deframer_unit #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] tape_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [35:0] data_word, [39:36] zero
	output logic        m_tlast,   // record_end
	output logic [3:0]  m_tuser    // [0] file_start, [1] record_start, [3:2] status
);

	logic                         accept;
	logic                         push;
	tisd_pkg::token_t             push_tok;
	logic                         q_valid;
	logic                         pop;
	tisd_pkg::token_t             q_head;
	logic [tisd_pkg::WORD_W-1:0]  data_word;
	logic                         file_start;
	logic                         record_start;
	tisd_pkg::status_t            status;

	assign accept = s_tvalid && s_tready;

	tisd_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.tape_byte(s_tdata),
		.push     (push),
		.push_tok (push_tok)
	);

	tisd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_tok(push_tok),
		.ready   (s_tready),
		.pop     (pop),
		.valid   (q_valid),
		.head    (q_head)
	);

	tisd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.data_word   (data_word),
		.file_start  (file_start),
		.record_start(record_start),
		.record_end  (m_tlast),
		.status      (status)
	);

	assign m_tdata = {4'b0000, data_word};
	assign m_tuser = {status, record_start, file_start};

	`TISD_ASSERT_NOW(a_status_clean, m_tvalid && status != tisd_pkg::ST_WORD, data_word == '0 && !m_tlast && !file_start && !record_start, "status request carries word fields")
	`TISD_ASSERT_NOW(a_one_start, m_tvalid, !(file_start && record_start), "file and record start together")
	`TISD_ASSERT_NEXT(a_halt_after_error, m_tvalid && m_tready && status != tisd_pkg::ST_WORD, !m_tvalid, "request after error")

endmodule

// ===== design/tisd_queue.sv =====
// ---------------------------------------------------------------------------
// tisd_queue
// Short token queue between the framing front end and the word back end.
// ---------------------------------------------------------------------------
module tisd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tisd_pkg::token_t push_tok,
	output logic             ready,
	input  logic             pop,
	output logic             valid,
	output tisd_pkg::token_t head
);

	tisd_pkg::token_t                  mem_q [tisd_pkg::QUEUE_DEPTH];
	logic [tisd_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [tisd_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [tisd_pkg::QPTR_W:0]         count_q;

	assign ready = (count_q != (tisd_pkg::QPTR_W+1)'(tisd_pkg::QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== design/tisd_front.sv =====
// ---------------------------------------------------------------------------
// tisd_front
// Record framing: parses length header and trailer, counts data bytes,
// and emits digit and status tokens into the queue.
// ---------------------------------------------------------------------------
module tisd_front #(
	parameter int LENGTH_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       tape_byte,
	output logic             push,
	output tisd_pkg::token_t push_tok
);

	tisd_pkg::phase_t                  phase_q, phase_d;
	logic [1:0]                        idx_q;
	logic [tisd_pkg::REC_LEN_W-1:0]    len_q;
	logic [23:0]                       trl_q;
	logic [1:0]                        mod3_q;
	logic                              odd_q;
	logic [LENGTH_BITS-1:0]            frames_q;
	logic [2:0]                        fiw_q;
	logic                              fs_pend_q;
	logic                              atm_q;
	logic                              first_q;
	logic                              halt_q;

	logic [tisd_pkg::REC_LEN_W-1:0]    full_len;
	logic [1:0]                        mod3_now;
	logic                              len_zero;
	logic                              len_bad;
	logic                              trl_bad;
	logic                              word_done;
	logic                              rec_done;
	logic                              live;

	assign live      = accept && !halt_q;
	assign full_len  = {tape_byte, len_q[tisd_pkg::REC_LEN_W-1:8]};
	assign mod3_now  = (idx_q == 2'd0) ? tisd_pkg::mod3_byte(tape_byte)
	                                   : tisd_pkg::mod3_add(mod3_q, tisd_pkg::mod3_byte(tape_byte));
	assign len_zero  = (full_len == '0);
	assign len_bad   = ((full_len >> LENGTH_BITS) != '0) || odd_q || (mod3_now != 2'd0);
	assign trl_bad   = ({tape_byte, trl_q} != len_q);
	assign word_done = (fiw_q == tisd_pkg::LAST_FRAME);
	assign rec_done  = word_done && (frames_q == LENGTH_BITS'(1));

	// next state
	always_comb begin
		phase_d = phase_q;
		if (live) begin
			unique case (phase_q)
				tisd_pkg::PH_DATA: begin
					if (rec_done) phase_d = tisd_pkg::PH_TRAILER;
				end
				tisd_pkg::PH_TRAILER: begin
					if (idx_q == 2'd3) phase_d = tisd_pkg::PH_HEADER;
				end
				default: begin
					phase_d = tisd_pkg::PH_HEADER;
					if (idx_q == 2'd3 && !len_zero && !len_bad) phase_d = tisd_pkg::PH_DATA;
				end
			endcase
		end
	end

	// token output
	always_comb begin
		push               = 1'b0;
		push_tok           = '0;
		push_tok.kind      = tisd_pkg::TK_DIGIT;
		push_tok.st        = tisd_pkg::ST_WORD;
		push_tok.six       = tape_byte[tisd_pkg::SIX_W-1:0];
		if (live) begin
			unique case (phase_q)
				tisd_pkg::PH_DATA: begin
					push               = 1'b1;
					push_tok.word_last = word_done;
					push_tok.fs        = word_done && fs_pend_q;
					push_tok.rs        = word_done && !fs_pend_q && first_q;
					push_tok.re        = rec_done;
				end
				tisd_pkg::PH_TRAILER: begin
					if (idx_q == 2'd3 && trl_bad) begin
						push          = 1'b1;
						push_tok      = '0;
						push_tok.kind = tisd_pkg::TK_STATUS;
						push_tok.st   = tisd_pkg::ST_BADTRAIL;
					end
				end
				default: begin
					if (idx_q == 2'd3 && ((len_zero && atm_q) || (!len_zero && len_bad))) begin
						push          = 1'b1;
						push_tok      = '0;
						push_tok.kind = tisd_pkg::TK_STATUS;
						push_tok.st   = len_zero ? tisd_pkg::ST_EOT : tisd_pkg::ST_BADLEN;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (live) begin
			unique case (phase_q)
				tisd_pkg::PH_DATA: begin
					frames_q <= frames_q - 1'b1;
				end
				tisd_pkg::PH_TRAILER: begin
					trl_q <= {tape_byte, trl_q[23:8]};
				end
				default: begin
					len_q  <= full_len;
					mod3_q <= mod3_now;
					if (idx_q == 2'd0) odd_q <= tape_byte[0];
					if (idx_q == 2'd3) frames_q <= full_len[LENGTH_BITS-1:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tisd_pkg::PH_HEADER;
			idx_q     <= '0;
			fiw_q     <= '0;
			fs_pend_q <= 1'b1;
			atm_q     <= 1'b0;
			first_q   <= 1'b0;
			halt_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (push && push_tok.kind == tisd_pkg::TK_STATUS) halt_q <= 1'b1;
			if (live) begin
				unique case (phase_q)
					tisd_pkg::PH_DATA: begin
						if (word_done) begin
							fiw_q     <= '0;
							fs_pend_q <= 1'b0;
							first_q   <= 1'b0;
						end else begin
							fiw_q <= fiw_q + 1'b1;
						end
						if (rec_done) idx_q <= '0;
					end
					tisd_pkg::PH_TRAILER: begin
						idx_q <= idx_q + 1'b1;
					end
					default: begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == 2'd3) begin
							if (len_zero) begin
								atm_q     <= 1'b1;
								fs_pend_q <= 1'b1;
							end else if (!len_bad) begin
								atm_q   <= 1'b0;
								first_q <= 1'b1;
								fiw_q   <= '0;
							end
						end
					end
				endcase
			end
		end
	end

endmodule

// ===== design/tisd_back.sv =====
// ---------------------------------------------------------------------------
// tisd_back
// Word assembly: shifts six-bit digits into a word and drives the
// registered result stream.
// ---------------------------------------------------------------------------
module tisd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  tisd_pkg::token_t              q_head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tisd_pkg::WORD_W-1:0]   data_word,
	output logic                          file_start,
	output logic                          record_start,
	output logic                          record_end,
	output tisd_pkg::status_t             status
);

	logic [tisd_pkg::ACC_W-1:0]   acc_q;
	logic [tisd_pkg::WORD_W-1:0]  data_q;
	logic                         fs_q;
	logic                         rs_q;
	logic                         re_q;
	tisd_pkg::status_t            st_q;
	logic                         valid_q;
	logic                         emits;
	logic                         out_free;

	assign emits    = (q_head.kind == tisd_pkg::TK_STATUS) || q_head.word_last;
	assign out_free = !valid_q || out_ready;
	assign pop      = q_valid && (!emits || out_free);

	assign out_valid    = valid_q;
	assign data_word    = data_q;
	assign file_start   = fs_q;
	assign record_start = rs_q;
	assign record_end   = re_q;
	assign status       = st_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (q_head.kind == tisd_pkg::TK_STATUS) begin
				data_q <= '0;
				fs_q   <= 1'b0;
				rs_q   <= 1'b0;
				re_q   <= 1'b0;
				st_q   <= q_head.st;
			end else if (q_head.word_last) begin
				data_q <= {acc_q, q_head.six};
				fs_q   <= q_head.fs;
				rs_q   <= q_head.rs;
				re_q   <= q_head.re;
				st_q   <= tisd_pkg::ST_WORD;
				acc_q  <= '0;
			end else begin
				acc_q <= {acc_q[tisd_pkg::ACC_W-tisd_pkg::SIX_W-1:0], q_head.six};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= pop && emits;
		end
	end

endmodule

// ===== dv/tb_tape_image_seven_track_deframer_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_tape_image_seven_track_deframer_unit
// Feeds a stream of well-formed seven-track tape records and tape marks,
// with random data and random gaps on both sides, and ends the tape with
// one randomly chosen terminating condition (end of tape, bad length or bad
// trailer) followed by bytes that must be ignored. A built-in deframer
// predicts each word and status request, and every request from the block
// is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_tape_image_seven_track_deframer_unit;

	localparam int LEN_BITS     = 32;
	localparam int TAPE_BYTES   = 1100;
	localparam int LONG_HOLD    = 300;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [3:0]        pad;
		logic [35:0]       word;
		logic              fs;
		logic              rs;
		logic              re;
		tisd_pkg::status_t st;
	} tape_result_t;

	typedef struct {
		logic [7:0] b;
		bit         hold;
	} tape_item_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic [3:0]  m_tuser;

	tape_item_t   tape_image[$];
	tape_result_t pending_words[$];
	tape_result_t got, want;

	// deframer prediction state
	tisd_pkg::phase_t ph;
	logic [1:0]  len_idx;
	logic [31:0] hdr_len, trl_len, frames_left;
	logic [2:0]  frame_cnt;
	logic [29:0] acc;
	bit          fs_pend, after_mark, first_pend, halted;

	int unsigned errors, bytes_sent, words_seen, records_sent, marks_sent, idle_cycles;
	int unsigned src_gap, src_burst, sink_hold, sink_burst, gap;
	int unsigned end_kind;
	bit          long_hold_done;

	tape_image_seven_track_deframer_unit #(.LENGTH_BITS(LEN_BITS)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic halt_with(input tisd_pkg::status_t s);
		tape_result_t r;
		r = '0;
		r.st = s;
		halted = 1'b1;
		pending_words.push_back(r);
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		tape_result_t r;
		logic [31:0]  shifted;
		if (halted)
			return;
		r = '0;
		if (ph == tisd_pkg::PH_DATA) begin
			frames_left = frames_left - 32'd1;
			if (frame_cnt < tisd_pkg::LAST_FRAME) begin
				acc = {acc[23:0], b[5:0]};
				frame_cnt = frame_cnt + 3'd1;
				if (frames_left == 32'd0) begin
					frame_cnt = 3'd0;
					acc = '0;
					ph = tisd_pkg::PH_TRAILER;
					len_idx = 2'd0;
					trl_len = '0;
				end
			end else begin
				r.word = {acc, b[5:0]};
				if (fs_pend) begin
					r.fs = 1'b1;
					fs_pend = 1'b0;
				end else if (first_pend) begin
					r.rs = 1'b1;
				end
				first_pend = 1'b0;
				frame_cnt = 3'd0;
				acc = '0;
				if (frames_left == 32'd0) begin
					r.re = 1'b1;
					ph = tisd_pkg::PH_TRAILER;
					len_idx = 2'd0;
					trl_len = '0;
				end
				r.st = tisd_pkg::ST_WORD;
				pending_words.push_back(r);
			end
			return;
		end
		shifted = 32'(b) << {len_idx, 3'b000};
		if (ph == tisd_pkg::PH_TRAILER) begin
			trl_len |= shifted;
			if (len_idx < 2'd3) begin
				len_idx = len_idx + 2'd1;
				return;
			end
			len_idx = 2'd0;
			ph = tisd_pkg::PH_HEADER;
			if (trl_len != hdr_len)
				halt_with(tisd_pkg::ST_BADTRAIL);
			else
				hdr_len = '0;
			return;
		end
		ph = tisd_pkg::PH_HEADER;
		if (len_idx == 2'd0)
			hdr_len = '0;
		hdr_len |= shifted;
		if (len_idx < 2'd3) begin
			len_idx = len_idx + 2'd1;
			return;
		end
		len_idx = 2'd0;
		if (hdr_len == 32'd0) begin
			if (after_mark) begin
				halt_with(tisd_pkg::ST_EOT);
			end else begin
				after_mark = 1'b1;
				fs_pend = 1'b1;
			end
			return;
		end
		if ((64'(hdr_len) >> LEN_BITS) != 64'd0 || (hdr_len % 32'd6) != 32'd0) begin
			halt_with(tisd_pkg::ST_BADLEN);
			return;
		end
		after_mark = 1'b0;
		first_pend = 1'b1;
		frames_left = hdr_len;
		frame_cnt = 3'd0;
		acc = '0;
		ph = tisd_pkg::PH_DATA;
	endtask

	// mostly short gaps, a few long ones
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 2);
		else if (r < 96)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	task automatic push_byte(input logic [7:0] b, input bit hold);
		tape_item_t it;
		it.b = b;
		it.hold = hold;
		tape_image.push_back(it);
	endtask

	task automatic push_len(input logic [31:0] len, input bit hold);
		push_byte(len[7:0], hold);
		push_byte(len[15:8], 1'b0);
		push_byte(len[23:16], 1'b0);
		push_byte(len[31:24], 1'b0);
		if (len == 32'd0)
			marks_sent++;
	endtask

	task automatic push_record(input int unsigned len, input bit bad_trailer, input bit hold);
		logic [31:0] mask;
		int          i;
		push_len(len, hold);
		for (i = 0; i < len; i++)
			push_byte(8'($urandom_range(0, 255)), 1'b0);
		do
			mask = $urandom;
		while (mask == 32'd0);
		push_len(bad_trailer ? (32'(len) ^ mask) : 32'(len), 1'b0);
		records_sent++;
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				deframe_byte(s_tdata);
				bytes_sent++;
				if (src_burst > 0) begin
					src_burst--;
					src_gap = 0;
				end else begin
					src_gap = idle_gap();
					if ($urandom_range(0, 49) == 0)
						src_burst = $urandom_range(30, 100);
				end
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (tape_image.size() > 0 &&
						!(tape_image[0].hold && pending_words.size() > 0)) begin
					s_tvalid <= 1'b1;
					s_tdata <= tape_image[0].b;
					void'(tape_image.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.pad = m_tdata[39:36];
				got.word = m_tdata[35:0];
				got.fs = m_tuser[0];
				got.rs = m_tuser[1];
				got.re = m_tlast;
				got.st = tisd_pkg::status_t'(m_tuser[3:2]);
				if (pending_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected request: got %h", $time, got);
				end else begin
					want = pending_words.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch: expected pad=%h word=%h fs=%b rs=%b re=%b st=%0d",
							$time, want.pad, want.word, want.fs, want.rs, want.re, want.st);
						$display("%0t:           actual pad=%h word=%h fs=%b rs=%b re=%b st=%0d",
							$time, got.pad, got.word, got.fs, got.rs, got.re, got.st);
					end
					if (want.st == tisd_pkg::ST_WORD)
						words_seen++;
				end
			end
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && bytes_sent >= 400) begin
				long_hold_done = 1'b1;
				sink_hold = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (sink_burst > 0) begin
				sink_burst--;
				m_tready <= 1'b1;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? idle_gap() : 0;
				if (gap > 0) begin
					sink_hold = gap - 1;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
					if ($urandom_range(0, 49) == 0)
						sink_burst = $urandom_range(30, 100);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, no request moved for %0d cycles", $time, IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned k, r;
		logic [31:0] bad_len;
		bit          last_mark, paused;

		ph = tisd_pkg::PH_HEADER;
		len_idx = 2'd0;
		hdr_len = '0;
		trl_len = '0;
		frames_left = '0;
		frame_cnt = 3'd0;
		acc = '0;
		fs_pend = 1'b1;
		after_mark = 1'b0;
		first_pend = 1'b0;
		halted = 1'b0;

		// directed: extreme data, record after record, tape mark, pause for drain
		push_len(32'd6, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h3F, 1'b0);
		push_byte(8'hC0, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h55, 1'b0);
		push_len(32'd6, 1'b0);
		records_sent++;
		push_record(12, 1'b0, 1'b0);
		push_len(32'd0, 1'b0);
		push_record(6, 1'b0, 1'b1);

		// random tape body
		last_mark = 1'b0;
		paused = 1'b0;
		while (tape_image.size() < TAPE_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 10 && !last_mark) begin
				push_len(32'd0, 1'b0);
				last_mark = 1'b1;
			end else begin
				if (r == 99)
					k = 50;
				else if (r >= 90)
					k = $urandom_range(7, 40);
				else
					k = $urandom_range(1, 6);
				push_record(6 * k, 1'b0, !paused && tape_image.size() > 800);
				if (tape_image.size() > 800)
					paused = 1'b1;
				last_mark = 1'b0;
			end
		end

		// terminating condition
		end_kind = $urandom_range(0, 2);
		case (end_kind)
			0: begin
				if (!last_mark)
					push_len(32'd0, 1'b0);
				push_len(32'd0, 1'b0);
			end
			1: begin
				bad_len = $urandom;
				if (bad_len % 32'd6 == 32'd0)
					bad_len = bad_len + 32'd1;
				push_len(bad_len, 1'b0);
			end
			default: push_record(6 * $urandom_range(1, 4), 1'b1, 1'b0);
		endcase
		// ignored once halted
		for (k = 0; k < 8; k++)
			push_byte(8'($urandom_range(0, 255)), 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (tape_image.size() > 0 || s_tvalid)
			@(posedge clk);
		while (pending_words.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d tape bytes: %0d records, %0d tape marks; checked %0d words.",
			bytes_sent, records_sent, marks_sent, words_seen);
		$display("Tape ended by condition %0d (0 end of tape, 1 bad length, 2 bad trailer).",
			end_kind);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
